// ----- hdl/simd_twister_random_generator_macros.svh -----
// ----------------------------------------------------------------------------
// Twister generator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef SIMD_TWISTER_RANDOM_GENERATOR_MACROS_SVH
`define SIMD_TWISTER_RANDOM_GENERATOR_MACROS_SVH

// check a property at every edge out of reset
`define STGEN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition is followed by a consequence (non-overlapping implication)
`define STGEN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/stgen_pkg.sv -----
// ----------------------------------------------------------------------------
// Twister generator package
// Shared types, constants and the per-entry recurrence of the generator.
// ----------------------------------------------------------------------------
package stgen_pkg;

  localparam int unsigned STATE_ENTRIES_DEF = 156;
  localparam int unsigned MIDDLE_OFFSET_DEF = 124;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam logic [31:0] SEED_MULT = 32'd1812433253;
  localparam int unsigned SHL_AMT   = 1;
  localparam int unsigned SHR_AMT   = 7;
  localparam int unsigned SEED_SHR  = 30;

  typedef logic [3:0][31:0] entry_t;

  localparam entry_t LANE_MASK = {32'h2d7ce57f, 32'hefef7f33, 32'hffad7fdd, 32'hf7f0bfff};

  typedef enum logic {
    OP_SEED = 1'b0,
    OP_DRAW = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] seed;
  } cmd_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } cmd_head_t;

  function automatic entry_t regen_entry(entry_t x, entry_t y, entry_t r);
    entry_t nv;
    for (int k = 0; k < 4; k++) begin
      nv[k] = x[(k + 1) % 4] ^ (y[k] << SHL_AMT) ^ (r[k] & LANE_MASK[k]) ^ (r[k] >> SHR_AMT);
    end
    return nv;
  endfunction

  function automatic logic [31:0] seed_step(logic [31:0] prev, logic [31:0] idx);
    logic [31:0] mixed;
    mixed = prev ^ (prev >> SEED_SHR);
    return SEED_MULT * mixed + idx;
  endfunction

endpackage

// ----- hdl/stgen_front.sv -----
// ----------------------------------------------------------------------------
// Twister generator front end
// Accepts command beats, tags them as seed or draw and queues them.
// ----------------------------------------------------------------------------
`include "simd_twister_random_generator_macros.svh"

module stgen_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [31:0]           seed_i,
  output stgen_pkg::cmd_head_t  head_o,
  input  logic                  pop_i
);
  import stgen_pkg::*;

  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t              q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              push;
  cmd_t              cmd_in;

  assign in_stall_o = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign cmd_in     = '{op: op_e'(cmd_i), seed: seed_i};

  assign head_o.vld = (cnt_q != '0);
  assign head_o.cmd = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  `STGEN_ASSERT(a_cnt_range, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `STGEN_ASSERT(a_pop_nonempty, !pop_i || (cnt_q != '0), "pop from empty queue")
  `STGEN_ASSERT_NEXT(a_push_grows, push && !pop_i, cnt_q == $past(cnt_q) + CNT_W'(1), "queue count did not grow")

endmodule

// ----- hdl/stgen_back.sv -----
// ----------------------------------------------------------------------------
// Twister generator back end
// Runs seeding, state regeneration and word draws against the state memory.
// ----------------------------------------------------------------------------
`include "simd_twister_random_generator_macros.svh"

module stgen_back #(
  parameter int unsigned STATE_ENTRIES = stgen_pkg::STATE_ENTRIES_DEF,
  parameter int unsigned MIDDLE_OFFSET = stgen_pkg::MIDDLE_OFFSET_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stgen_pkg::cmd_head_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          random_word_o
);
  import stgen_pkg::*;

  localparam int unsigned TOTAL_WORDS = 4 * STATE_ENTRIES;
  localparam int unsigned PTR_W       = $clog2(TOTAL_WORDS + 1);
  localparam int unsigned IDX_W       = $clog2(STATE_ENTRIES);
  localparam int unsigned LAST_IDX    = STATE_ENTRIES - 1;
  localparam int unsigned Y_START     = MIDDLE_OFFSET % STATE_ENTRIES;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEED   = 3'd1;
  localparam logic [2:0] ST_RG_PRE = 3'd2;
  localparam logic [2:0] ST_RG_RD  = 3'd3;
  localparam logic [2:0] ST_RG_WR  = 3'd4;
  localparam logic [2:0] ST_DRAW   = 3'd5;

  entry_t             st_mem_q [STATE_ENTRIES];
  logic [STATE_ENTRIES-1:0] ent_vld_q;

  logic [2:0]       state_q, state_d;
  logic [PTR_W-1:0] ptr_q;
  logic [PTR_W-1:0] seed_cnt_q;
  logic [31:0]      prev_q;
  logic [2:0][31:0] lane_q;
  logic [IDX_W-1:0] rg_idx_q;
  logic [IDX_W-1:0] rg_y_q;
  entry_t           r_q;
  entry_t           rd_a_q, rd_b_q;
  logic             rd_a_vld_q, rd_b_vld_q;
  logic             out_vld_q;
  logic [31:0]      out_word_q;

  logic             rd_a_en, rd_b_en, wr_en;
  logic [IDX_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
  entry_t           wr_data;
  entry_t           x_ent, y_ent, new_ent;
  logic [31:0]      seed_word;
  logic             out_free, out_load;
  logic             seed_start, seed_done, rg_start, rg_done;

  assign x_ent     = rd_a_vld_q ? rd_a_q : '0;
  assign y_ent     = rd_b_vld_q ? rd_b_q : '0;
  assign new_ent   = regen_entry(x_ent, y_ent, r_q);
  assign seed_word = seed_step(prev_q, 32'(seed_cnt_q));
  assign out_free  = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    rd_a_en    = 1'b0;
    rd_b_en    = 1'b0;
    wr_en      = 1'b0;
    rd_a_addr  = rg_idx_q;
    rd_b_addr  = rg_y_q;
    wr_addr    = rg_idx_q;
    wr_data    = new_ent;
    pop_o      = 1'b0;
    out_load   = 1'b0;
    seed_start = 1'b0;
    seed_done  = 1'b0;
    rg_start   = 1'b0;
    rg_done    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.vld) begin
          if (head_i.cmd.op == OP_SEED) begin
            seed_start = 1'b1;
            state_d    = ST_SEED;
          end else if (ptr_q == PTR_W'(TOTAL_WORDS)) begin
            rg_start = 1'b1;
            state_d  = ST_RG_PRE;
          end else begin
            rd_a_en   = 1'b1;
            rd_a_addr = ptr_q[IDX_W+1:2];
            state_d   = ST_DRAW;
          end
        end
      end
      ST_SEED: begin
        wr_addr = seed_cnt_q[IDX_W+1:2];
        wr_data = {seed_word, lane_q};
        wr_en   = (seed_cnt_q[1:0] == 2'b11);
        if (seed_cnt_q == PTR_W'(TOTAL_WORDS - 1)) begin
          seed_done = 1'b1;
          pop_o     = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_RG_PRE: begin
        rd_a_en   = 1'b1;
        rd_a_addr = IDX_W'(LAST_IDX);
        state_d   = ST_RG_RD;
      end
      ST_RG_RD: begin
        rd_a_en = 1'b1;
        rd_b_en = 1'b1;
        state_d = ST_RG_WR;
      end
      ST_RG_WR: begin
        wr_en = 1'b1;
        if (rg_idx_q == IDX_W'(LAST_IDX)) begin
          rg_done = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_RG_RD;
        end
      end
      ST_DRAW: begin
        if (out_free) begin
          out_load = 1'b1;
          pop_o    = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      st_mem_q[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_q <= st_mem_q[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_q <= st_mem_q[rd_b_addr];
    end
    if (seed_start) begin
      prev_q    <= head_i.cmd.seed;
      lane_q[0] <= head_i.cmd.seed;
    end else if (state_q == ST_SEED) begin
      prev_q <= seed_word;
      if (seed_cnt_q[1:0] != 2'b11) begin
        lane_q[seed_cnt_q[1:0]] <= seed_word;
      end
    end
    if (state_q == ST_RG_RD && rg_idx_q == '0) begin
      r_q <= x_ent;
    end else if (state_q == ST_RG_WR) begin
      r_q <= new_ent;
    end
    if (out_load) begin
      out_word_q <= x_ent[ptr_q[1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ptr_q      <= '0;
      seed_cnt_q <= '0;
      rg_idx_q   <= '0;
      rg_y_q     <= '0;
      ent_vld_q  <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_a_en) begin
        rd_a_vld_q <= ent_vld_q[rd_a_addr];
      end
      if (rd_b_en) begin
        rd_b_vld_q <= ent_vld_q[rd_b_addr];
      end
      if (seed_start) begin
        seed_cnt_q <= PTR_W'(1);
      end else if (state_q == ST_SEED) begin
        seed_cnt_q <= seed_cnt_q + PTR_W'(1);
      end
      if (rg_start) begin
        rg_idx_q <= '0;
        rg_y_q   <= IDX_W'(Y_START);
      end else if (state_q == ST_RG_WR) begin
        rg_idx_q <= rg_idx_q + IDX_W'(1);
        rg_y_q   <= (rg_y_q == IDX_W'(LAST_IDX)) ? '0 : rg_y_q + IDX_W'(1);
      end
      if (seed_done) begin
        ptr_q <= PTR_W'(TOTAL_WORDS);
      end else if (rg_done) begin
        ptr_q <= '0;
      end else if (out_load) begin
        ptr_q <= ptr_q + PTR_W'(1);
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign random_word_o = out_word_q;

  `STGEN_ASSERT(a_ptr_range, ptr_q <= PTR_W'(TOTAL_WORDS), "word pointer beyond end")
  `STGEN_ASSERT(a_draw_in_range, (state_q != ST_DRAW) || (ptr_q < PTR_W'(TOTAL_WORDS)), "draw past end of state")
  `STGEN_ASSERT_NEXT(a_regen_done, rg_done, (ptr_q == '0) && (state_q == ST_IDLE), "regeneration did not rewind pointer")
  `STGEN_ASSERT_NEXT(a_seed_done, seed_done, ptr_q == PTR_W'(TOTAL_WORDS), "seeding did not park pointer")

endmodule

// ----- hdl/simd_twister_random_generator.sv -----
// ----------------------------------------------------------------------------
// SIMD twister random generator
// Command beats in, 32-bit pseudo-random words out.
// ----------------------------------------------------------------------------
// Input beats carry cmd_i and seed_i. A seed beat (cmd 0) rebuilds the whole
// state from seed_i and returns nothing; a draw beat (cmd 1) returns one word
// on the output channel, low lane of each state entry first.
// A two-entry command queue sits between intake and the execution engine, so
// the input keeps taking beats while a word waits in the output register.
// A plain draw reads its state entry in ST_IDLE and loads the output register
// in ST_DRAW once that register is free. A seed beat holds the engine for one
// multiply-add per state word. The first draw after a seed, or after every
// 4*STATE_ENTRIES words, first regenerates the state in a read-then-write loop
// over the state memory, two state-memory reads and one write per entry.
// Reset clears the word pointer and marks every state entry as zero, so draws
// without a seed return zeros. While out_stall_i is high the output word
// holds; the engine stalls behind it and the queue fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
module simd_twister_random_generator #(
  parameter int unsigned STATE_ENTRIES = stgen_pkg::STATE_ENTRIES_DEF,
  parameter int unsigned MIDDLE_OFFSET = stgen_pkg::MIDDLE_OFFSET_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_word_o
);
  import stgen_pkg::*;

  cmd_head_t head;
  logic      pop;

  stgen_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .seed_i     (seed_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  stgen_back #(
    .STATE_ENTRIES (STATE_ENTRIES),
    .MIDDLE_OFFSET (MIDDLE_OFFSET)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_o (random_word_o)
  );

endmodule

// ----- bench/simd_twister_random_generator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Twister random generator testbench
// Sends seed and draw beats under several idle and stall mixes. A scoreboard
// keeps its own copy of the twister state, predicts every drawn word at intake
// and compares each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module simd_twister_random_generator_test;
  import stgen_pkg::*;

  localparam int unsigned ENTRIES      = STATE_ENTRIES_DEF;
  localparam int unsigned OFFSET       = MIDDLE_OFFSET_DEF;
  localparam int unsigned WORDS        = 4 * ENTRIES;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = WORDS + 2 * ENTRIES + 32;
  localparam int unsigned REPORT_MAX   = 10;

  class twister_scoreboard;
    entry_t      twist [ENTRIES];
    int unsigned word_ptr;
    logic [31:0] pending_words [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned reseeds;
    int unsigned regens;

    function new();
      foreach (twist[i]) twist[i] = '0;
      word_ptr = 0;
      errors   = 0;
      checked  = 0;
      reseeds  = 0;
      regens   = 0;
    endfunction

    function void regenerate();
      entry_t prev_new;
      entry_t x;
      entry_t y;
      entry_t fresh;
      prev_new = twist[ENTRIES-1];
      for (int unsigned i = 0; i < ENTRIES; i++) begin
        x = twist[i];
        y = twist[(i + OFFSET) % ENTRIES];
        for (int k = 0; k < 4; k++) begin
          fresh[k] = x[(k + 1) % 4] ^ (y[k] << SHL_AMT)
                   ^ (prev_new[k] & LANE_MASK[k]) ^ (prev_new[k] >> SHR_AMT);
        end
        twist[i] = fresh;
        prev_new = fresh;
      end
      regens++;
    endfunction

    function void reseed(logic [31:0] seed);
      logic [31:0] prev;
      prev = seed;
      twist[0][0] = seed;
      for (int unsigned w = 1; w < WORDS; w++) begin
        prev = SEED_MULT * (prev ^ (prev >> SEED_SHR)) + w;
        twist[w / 4][w % 4] = prev;
      end
      word_ptr = WORDS;
      reseeds++;
    endfunction

    function void note_command(op_e op, logic [31:0] seed);
      if (op == OP_SEED) begin
        reseed(seed);
      end else begin
        if (word_ptr >= WORDS) begin
          regenerate();
          word_ptr = 0;
        end
        pending_words.push_back(twist[word_ptr / 4][word_ptr % 4]);
        word_ptr++;
      end
    endfunction

    function void check_word(logic [31:0] got);
      logic [31:0] want;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) $display("random_word %h arrived with none expected", got);
      end else begin
        want = pending_words.pop_front();
        checked++;
        if (got !== want) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("random_word mismatch on word %0d: expected %h, actual %h",
                     checked, want, got);
          end
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        cmd_i       = 1'b0;
  logic [31:0] seed_i      = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] random_word_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  twister_scoreboard sb;

  simd_twister_random_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .seed_i        (seed_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_o (random_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simd_twister_random_generator_test NOT OK");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_command(op_e'(cmd_i), seed_i);
      if (out_valid_o && !out_stall_i) sb.check_word(random_word_o);
    end
  end

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input op_e op, input logic [31:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    seed_i     <= seed;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_for_words();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending_words.size() != 0);
  endtask

  initial begin
    int unsigned sent;
    int unsigned budget;
    int unsigned run_len;
    logic [31:0] seed_val;
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // unseeded draws read the cleared state
    repeat (3) send_beat(OP_DRAW, $urandom);
    send_beat(OP_SEED, 32'h0000_0000);
    repeat (2) send_beat(OP_DRAW, 32'hffff_ffff);
    send_beat(OP_SEED, 32'hffff_ffff);
    repeat (2) send_beat(OP_DRAW, 32'h0000_0000);
    send_beat(OP_SEED, 32'h0000_0001);
    send_beat(OP_DRAW, 32'h8000_0000);
    send_beat(OP_SEED, 32'h8000_0000);
    send_beat(OP_SEED, 32'h5555_aaaa);
    repeat (3) send_beat(OP_DRAW, 32'haaaa_5555);
    wait_for_words();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      sent   = 0;
      budget = (p == 0) ? 720 : 240;
      if (p == 0) begin
        // run past the end of the state so it regenerates from seeded contents
        send_beat(OP_SEED, $urandom);
        for (int unsigned n = 0; n < WORDS + 80; n++) send_beat(OP_DRAW, $urandom);
        sent = WORDS + 81;
      end
      while (sent < budget) begin
        if ($urandom_range(99) < 30) begin
          case ($urandom_range(7))
            0:       seed_val = 32'h0000_0000;
            1:       seed_val = 32'hffff_ffff;
            default: seed_val = $urandom;
          endcase
          send_beat(OP_SEED, seed_val);
          sent++;
        end else begin
          run_len = $urandom_range(30, 1);
          for (int unsigned n = 0; n < run_len; n++) send_beat(OP_DRAW, $urandom);
          sent += run_len;
        end
      end
      wait_for_words();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("checked %0d words across %0d reseeds and %0d state regenerations",
             sb.checked, sb.reseeds, sb.regens);
    $display("idle mixes: none, sender 74%%, receiver 74%%, both 13%%; %0d failures",
             sb.errors);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("simd_twister_random_generator_test OK");
    end else begin
      $display("simd_twister_random_generator_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/stgen_pkg.sv
hdl/stgen_front.sv
hdl/stgen_back.sv
hdl/simd_twister_random_generator.sv
bench/simd_twister_random_generator_test.sv
